// ===== rtl/core/conv3x3_relu_stream_top_assert.svh =====
// ----------------------------------------------------------------------------
// conv3x3_relu_stream_top_assert.svh
// Assertion macros for the 3x3 convolution stream checker.
// ----------------------------------------------------------------------------
`ifndef CONV3X3_RELU_STREAM_TOP_ASSERT_SVH
`define CONV3X3_RELU_STREAM_TOP_ASSERT_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define C3R_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, sampled on clk, off while rst_n is low
`define C3R_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/core/c3r_pkg.sv =====
// ----------------------------------------------------------------------------
// c3r_pkg
// Shared widths, reset values, register codes and stage types.
// ----------------------------------------------------------------------------
package c3r_pkg;

  localparam int PIX_W      = 8;
  localparam int ROW_W      = 12;
  localparam int COL_W      = 10;
  localparam int WIDTH_W    = 11;
  localparam int HEIGHT_W   = 13;
  localparam int KERNEL_W   = 24;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  localparam int DEF_MAX_WIDTH = 1024;
  localparam int DEF_COEF_BITS = 8;
  localparam int HEIGHT_MAX    = 4096;
  localparam int MIN_DIM       = 3;

  localparam logic [WIDTH_W-1:0]  RST_IMAGE_WIDTH   = 11'd1024;
  localparam logic [HEIGHT_W-1:0] RST_IMAGE_HEIGHT  = 13'd1024;
  localparam logic [KERNEL_W-1:0] RST_KERNEL_TOP    = 24'hFFFFFF;
  localparam logic [KERNEL_W-1:0] RST_KERNEL_MIDDLE = 24'hFF08FF;
  localparam logic [KERNEL_W-1:0] RST_KERNEL_BOTTOM = 24'hFFFFFF;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IMAGE_WIDTH   = 3'd0,
    REG_IMAGE_HEIGHT  = 3'd1,
    REG_KERNEL_TOP    = 3'd2,
    REG_KERNEL_MIDDLE = 3'd3,
    REG_KERNEL_BOTTOM = 3'd4
  } cfg_reg_t;

  // per-item tags carried alongside the datapath
  typedef struct packed {
    logic             cv;
    logic             calc;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic             last;
  } c3r_meta_t;

endpackage

// ===== rtl/core/c3r_if.sv =====
// ----------------------------------------------------------------------------
// c3r_if
// Valid/ready channels: pixel input, result output, register write.
// ----------------------------------------------------------------------------
interface c3r_in_if;
  import c3r_pkg::*;
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] pixel;
  logic             frame_start;
  modport source (output valid, output pixel, output frame_start, input ready);
  modport sink (input valid, input pixel, input frame_start, output ready);
endinterface

interface c3r_out_if;
  import c3r_pkg::*;
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] out_pixel;
  logic [ROW_W-1:0] out_row;
  logic [COL_W-1:0] out_col;
  logic             out_valid;
  logic             frame_end;
  modport source (output valid, output out_pixel, output out_row, output out_col,
                  output out_valid, output frame_end, input ready);
  modport sink (input valid, input out_pixel, input out_row, input out_col,
                input out_valid, input frame_end, output ready);
endinterface

interface c3r_cfg_if;
  import c3r_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// ===== rtl/core/c3r_ram.sv =====
// ----------------------------------------------------------------------------
// c3r_ram
// Simple dual-port RAM, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module c3r_ram #(
  parameter int WIDTH = c3r_pkg::PIX_W,
  parameter int DEPTH = c3r_pkg::DEF_MAX_WIDTH
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/core/c3r_cell.sv =====
// ----------------------------------------------------------------------------
// c3r_cell
// One window tap: holds a pixel, passes it on, registers pixel x coefficient.
// ----------------------------------------------------------------------------
module c3r_cell #(
  parameter int COEF_BITS = c3r_pkg::DEF_COEF_BITS
) (
  input  logic                                      clk,
  input  logic                                      en,
  input  logic [c3r_pkg::PIX_W-1:0]                 pix_in,
  input  logic signed [COEF_BITS-1:0]               coef,
  output logic [c3r_pkg::PIX_W-1:0]                 pix_out,
  output logic signed [COEF_BITS+c3r_pkg::PIX_W-1:0] prod
);
  import c3r_pkg::*;

  localparam int PW = COEF_BITS + PIX_W;

  logic [PIX_W-1:0]  pix_r;
  logic signed [PW-1:0] prod_r;
  logic signed [PW:0]   prod_full;

  assign prod_full = coef * $signed({1'b0, pix_in});

  always_ff @(posedge clk) begin
    if (en) begin
      pix_r  <= pix_in;
      prod_r <= $signed(prod_full[PW-1:0]);
    end
  end

  assign pix_out = pix_r;
  assign prod    = prod_r;

endmodule

// ===== rtl/core/conv3x3_relu_stream_top.sv =====
// ----------------------------------------------------------------------------
// conv3x3_relu_stream_top
// Streaming 3x3 signed-kernel convolution with ReLU over raster gray pixels.
//
//   channel   | dir | transfer                        | payload
//   ----------+-----+---------------------------------+---------------------------
//   in_chan   | in  | valid & ready                   | pixel, frame_start
//   out_chan  | out | valid & ready                   | out_pixel/row/col/valid,
//             |     |                                 | frame_end
//   cfg_chan  | in  | valid & ready (ready always 1)  | index, data
//
// One pixel per cycle unless stalled; a result passes stage 1 (RAM read), the
// cells, the row sums and then the output register. The rate is set by the
// single read port of each line buffer RAM. rst_n is synchronous; after it all
// MAX_WIDTH line buffer addresses are zeroed, in_chan.ready low meanwhile,
// register writes still taken. A held result with out_chan.ready low stalls the
// whole pipe; otherwise the output register is reloaded as its result transfers.
// ----------------------------------------------------------------------------
module conv3x3_relu_stream_top #(
  parameter int MAX_WIDTH = c3r_pkg::DEF_MAX_WIDTH,
  parameter int COEF_BITS = c3r_pkg::DEF_COEF_BITS
) (
  input  logic       clk,
  input  logic       rst_n,
  c3r_in_if.sink     in_chan,
  c3r_out_if.source  out_chan,
  c3r_cfg_if.sink    cfg_chan
);
  import c3r_pkg::*;

  localparam int CW   = $clog2(MAX_WIDTH);
  localparam int WCMP = (CW + 1 > WIDTH_W) ? CW + 1 : WIDTH_W;
  localparam int KXW  = 3 * COEF_BITS + KERNEL_W;
  localparam int PW   = COEF_BITS + PIX_W;
  localparam int RSW  = PW + 2;
  localparam int TW   = PW + 4;

  logic [WIDTH_W-1:0]  width_r;
  logic [HEIGHT_W-1:0] height_r;
  logic [KERNEL_W-1:0] kern_r [3];

  logic          clr_r;
  logic [CW-1:0] clr_addr_r;

  logic [ROW_W-1:0] row_r, row_nxt, r_cur, last_row;
  logic [CW-1:0]    col_r, col_nxt, c_cur, last_col;
  logic [WCMP-1:0]  wext;

  logic adv, in_fire, cell_en;

  c3r_meta_t meta_new, meta_s1_r, meta_s2_r, meta_s3_r;
  logic      s1_v_r, s2_v_r, s3_v_r;

  logic [CW-1:0]    idx_s1_r;
  logic [PIX_W-1:0] p_s1_r, wlo_r, up_rdata, lo_rdata, up_s1;
  logic             hit_r;

  logic             up_we, lo_we;
  logic [CW-1:0]    up_waddr, lo_waddr;
  logic [PIX_W-1:0] up_wdata, lo_wdata;

  logic [KXW-1:0]              kx      [3];
  logic signed [COEF_BITS-1:0] coef    [3][3];
  logic [PIX_W-1:0]            col_in  [3];
  logic [PIX_W-1:0]            tap_in  [3][3];
  logic [PIX_W-1:0]            tap     [3][3];
  logic signed [PW-1:0]        prod    [3][3];
  logic signed [RSW-1:0]       row_sum_r [3];
  logic signed [TW-1:0]        total;

  logic             out_v_r, out_cv_r, out_last_r;
  logic [PIX_W-1:0] out_pix_r;
  logic [ROW_W-1:0] out_row_r;
  logic [COL_W-1:0] out_col_r;

  // register port
  assign cfg_chan.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r   <= RST_IMAGE_WIDTH;
      height_r  <= RST_IMAGE_HEIGHT;
      kern_r[0] <= RST_KERNEL_TOP;
      kern_r[1] <= RST_KERNEL_MIDDLE;
      kern_r[2] <= RST_KERNEL_BOTTOM;
    end else if (cfg_chan.valid) begin
      unique case (cfg_reg_t'(cfg_chan.index))
        REG_IMAGE_WIDTH:   width_r   <= cfg_chan.data[WIDTH_W-1:0];
        REG_IMAGE_HEIGHT:  height_r  <= cfg_chan.data[HEIGHT_W-1:0];
        REG_KERNEL_TOP:    kern_r[0] <= cfg_chan.data[KERNEL_W-1:0];
        REG_KERNEL_MIDDLE: kern_r[1] <= cfg_chan.data[KERNEL_W-1:0];
        REG_KERNEL_BOTTOM: kern_r[2] <= cfg_chan.data[KERNEL_W-1:0];
        default: ;
      endcase
    end
  end

  // frame geometry, saturated
  assign wext = WCMP'(width_r);

  always_comb begin
    priority if (wext < WCMP'(MIN_DIM)) begin
      last_col = CW'(MIN_DIM - 1);
    end else if (wext > WCMP'(MAX_WIDTH)) begin
      last_col = CW'(MAX_WIDTH - 1);
    end else begin
      last_col = CW'(wext - 1'b1);
    end
    priority if (height_r < HEIGHT_W'(MIN_DIM)) begin
      last_row = ROW_W'(MIN_DIM - 1);
    end else if (height_r > HEIGHT_W'(HEIGHT_MAX)) begin
      last_row = ROW_W'(HEIGHT_MAX - 1);
    end else begin
      last_row = ROW_W'(height_r - 1'b1);
    end
  end

  // handshake
  assign adv            = !out_v_r || out_chan.ready;
  assign in_chan.ready  = adv && !clr_r;
  assign in_fire        = in_chan.valid && in_chan.ready;
  assign cell_en        = adv && s1_v_r;

  // position of the incoming pixel
  always_comb begin
    r_cur = in_chan.frame_start ? '0 : row_r;
    c_cur = in_chan.frame_start ? '0 : col_r;

    meta_new.cv   = (r_cur != '0) && (c_cur != '0);
    meta_new.calc = (r_cur > ROW_W'(1)) && (c_cur > CW'(1));
    meta_new.row  = meta_new.cv ? ROW_W'(r_cur - 1'b1) : '0;
    meta_new.col  = meta_new.cv ? COL_W'(c_cur - 1'b1) : '0;
    meta_new.last = (c_cur >= last_col) && (r_cur >= last_row);

    if (c_cur >= last_col) begin
      col_nxt = '0;
      row_nxt = (r_cur >= last_row) ? '0 : ROW_W'(r_cur + 1'b1);
    end else begin
      col_nxt = CW'(c_cur + 1'b1);
      row_nxt = r_cur;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r <= '0;
      col_r <= '0;
    end else if (in_fire) begin
      row_r <= row_nxt;
      col_r <= col_nxt;
    end
  end

  // line buffer zeroing after reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r      <= 1'b1;
      clr_addr_r <= '0;
    end else if (clr_r) begin
      clr_addr_r <= CW'(clr_addr_r + 1'b1);
      if (clr_addr_r == CW'(MAX_WIDTH - 1)) begin
        clr_r <= 1'b0;
      end
    end
  end

  // line buffers: lower holds the previous line, upper the one before
  assign lo_we    = clr_r || in_fire;
  assign lo_waddr = clr_r ? clr_addr_r : c_cur;
  assign lo_wdata = clr_r ? '0 : in_chan.pixel;

  assign up_we    = clr_r || cell_en;
  assign up_waddr = clr_r ? clr_addr_r : idx_s1_r;
  assign up_wdata = clr_r ? '0 : lo_rdata;

  c3r_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_lb_lower (
    .clk   (clk),
    .we    (lo_we),
    .waddr (lo_waddr),
    .wdata (lo_wdata),
    .re    (in_fire),
    .raddr (c_cur),
    .rdata (lo_rdata)
  );

  c3r_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_lb_upper (
    .clk   (clk),
    .we    (up_we),
    .waddr (up_waddr),
    .wdata (up_wdata),
    .re    (in_fire),
    .raddr (c_cur),
    .rdata (up_rdata)
  );

  // stage 1: RAM read in flight
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      hit_r  <= 1'b0;
    end else if (adv) begin
      s1_v_r <= in_fire;
      if (in_fire) begin
        hit_r <= s1_v_r && (idx_s1_r == c_cur);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      meta_s1_r <= meta_new;
      idx_s1_r  <= c_cur;
      p_s1_r    <= in_chan.pixel;
    end
    if (cell_en) begin
      wlo_r <= lo_rdata;
    end
  end

  // upper write of the previous item lands on the same column: forward it
  assign up_s1 = hit_r ? wlo_r : up_rdata;

  assign col_in[0] = up_s1;
  assign col_in[1] = lo_rdata;
  assign col_in[2] = p_s1_r;

  // window: three rows of three cells, new column enters at the right
  for (genvar gi = 0; gi < 3; gi++) begin : g_row
    assign kx[gi] = KXW'(kern_r[gi]);
    for (genvar gj = 0; gj < 3; gj++) begin : g_tap
      assign coef[gi][gj] = $signed(kx[gi][gj*COEF_BITS +: COEF_BITS]);
      if (gj == 2) begin : g_head
        assign tap_in[gi][gj] = col_in[gi];
      end else begin : g_link
        assign tap_in[gi][gj] = tap[gi][gj+1];
      end
      c3r_cell #(.COEF_BITS(COEF_BITS)) u_cell (
        .clk     (clk),
        .en      (cell_en),
        .pix_in  (tap_in[gi][gj]),
        .coef    (coef[gi][gj]),
        .pix_out (tap[gi][gj]),
        .prod    (prod[gi][gj])
      );
    end
  end

  // stages 2 and 3: cell products, then row sums; the total feeds the output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
    end else if (adv) begin
      s2_v_r <= s1_v_r;
      s3_v_r <= s2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      meta_s2_r <= meta_s1_r;
      meta_s3_r <= meta_s2_r;
      for (int i = 0; i < 3; i++) begin
        row_sum_r[i] <= RSW'(prod[i][0]) + RSW'(prod[i][1]) + RSW'(prod[i][2]);
      end
    end
  end

  assign total = TW'(row_sum_r[0]) + TW'(row_sum_r[1]) + TW'(row_sum_r[2]);

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (adv) begin
      out_v_r <= s3_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_pix_r  <= (meta_s3_r.calc && !total[TW-1]) ? total[PIX_W-1:0] : '0;
      out_row_r  <= meta_s3_r.row;
      out_col_r  <= meta_s3_r.col;
      out_cv_r   <= meta_s3_r.cv;
      out_last_r <= meta_s3_r.last;
    end
  end

  assign out_chan.valid     = out_v_r;
  assign out_chan.out_pixel = out_pix_r;
  assign out_chan.out_row   = out_row_r;
  assign out_chan.out_col   = out_col_r;
  assign out_chan.out_valid = out_cv_r;
  assign out_chan.frame_end = out_last_r;

endmodule

// ===== rtl/core/c3r_checker.sv =====
// ----------------------------------------------------------------------------
// c3r_checker
// Port-level checks on the convolution stream, bound to the top level.
// ----------------------------------------------------------------------------
`include "conv3x3_relu_stream_top_assert.svh"

module c3r_checker (
  input logic       clk,
  input logic       rst_n,
  c3r_in_if.sink    in_chan,
  c3r_out_if.source out_chan
);
  import c3r_pkg::*;

  `C3R_ASSERT_NEXT(a_out_hold, out_chan.valid && !out_chan.ready, out_chan.valid && $stable(out_chan.out_pixel) && $stable(out_chan.frame_end), "result changed while stalled")

  `C3R_ASSERT_NOW(a_no_centre_zero, out_chan.valid && !out_chan.out_valid, out_chan.out_pixel == '0 && out_chan.out_row == '0 && out_chan.out_col == '0, "no-centre result not zero")

  `C3R_ASSERT_NOW(a_border_zero, out_chan.valid && (out_chan.out_pixel != '0), out_chan.out_valid && (out_chan.out_row != '0) && (out_chan.out_col != '0), "nonzero pixel on border centre")

  `C3R_ASSERT_NOW(a_after_reset, !$past(rst_n), !in_chan.ready && !out_chan.valid, "activity right after reset")

endmodule

bind conv3x3_relu_stream_top c3r_checker u_c3r_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .in_chan  (in_chan),
  .out_chan (out_chan)
);
